/* hdl/sirt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_pkg: shared types and constants of the stuck-ID retry tracker
// Table size, configuration register map, action codes, the search token that
// walks the cell chain and the helpers that size its fields.
// ----------------------------------------------------------------------------
package sirt_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 64;
    localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Field widths.
    localparam int ID_W    = 31;
    localparam int HITS_W  = 8;
    localparam int MOVES_W = 4;
    localparam int INDEX_W = 6;

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [HITS_W-1:0] HITS_MAX = '1;

    // Register indexes (byte address is four times the index).
    typedef enum logic [2:0] {
        REG_MOVE_THRESHOLD  = 3'd0,
        REG_ABORT_THRESHOLD = 3'd1,
        REG_MOVE_LIMIT      = 3'd2,
        REG_Y_MOVE_AFTER    = 3'd3,
        REG_COUNT_DECREMENT = 3'd4
    } t_reg_idx;

    // Result action codes.
    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_COUNTED  = 3'd1,
        ACT_INSERTED = 3'd2,
        ACT_MOVE     = 3'd3,
        ACT_ABORT    = 3'd4,
        ACT_FULL     = 3'd5
    } t_action;

    // Top-level control states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BUSY  = 2'd1,
        ST_DRAIN = 2'd2
    } t_state;

    // Configuration values broadcast to every cell.
    typedef struct packed {
        logic [HITS_W-1:0]  move_threshold;
        logic [HITS_W-1:0]  abort_threshold;
        logic [MOVES_W-1:0] move_limit;
        logic [MOVES_W-1:0] y_move_after;
        logic [HITS_W-1:0]  count_decrement;
    } t_cfg;

    // Search token handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic               active;
        logic [ID_W-1:0]    id;
        logic [CNT_W-1:0]   used;
        logic [SLOT_W-1:0]  slot;
        logic               done;
        t_action            action;
        logic [SLOT_W-1:0]  res_slot;
        logic [HITS_W-1:0]  hits;
        logic [MOVES_W-1:0] moves;
        logic               move_y;
    } t_tok;

    // Low six bits of a slot number, zero-extended for small tables.
    function automatic logic [INDEX_W-1:0] slot_to_index(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W+INDEX_W-1:0] ext;
        ext = {{INDEX_W{1'b0}}, slot};
        return ext[INDEX_W-1:0];
    endfunction

endpackage

/* hdl/sirt_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_in_if: input event channel
// Valid/ready channel that carries one step event or clear command.
// ----------------------------------------------------------------------------
interface sirt_in_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [sirt_pkg::ID_W-1:0]  track_id;
    logic                       step_is_zero;

    modport source (output valid, command, track_id, step_is_zero, input ready);
    modport sink   (input valid, command, track_id, step_is_zero, output ready);
endinterface

/* hdl/sirt_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_out_if: result channel
// Valid/ready channel that carries one tracker result.
// ----------------------------------------------------------------------------
interface sirt_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    action;
    logic [sirt_pkg::INDEX_W-1:0]  entry_index;
    logic [sirt_pkg::HITS_W-1:0]   hit_count;
    logic [sirt_pkg::MOVES_W-1:0]  move_count;
    logic                          move_y;

    modport source (output valid, action, entry_index, hit_count, move_count, move_y,
                    input ready);
    modport sink   (input valid, action, entry_index, hit_count, move_count, move_y,
                    output ready);
endinterface

/* hdl/stuck_id_retry_tracker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuck_id_retry_tracker_unit: stuck-ID retry tracker
// Keeps a table of identifiers that took zero-length steps and decides per
// event whether to count, insert, order a move, order an abort or report a
// full table. The table is a chain of cells walked by a search token.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_ch     sink       valid / ready        command, track_id, step_is_zero
//  out_ch    source     valid / ready        action, entry_index, hit_count,
//                                            move_count, move_y
//  apb       slave      psel/penable/pready  paddr, pwdata, prdata
//
// A zero-step event goes from the launch register through the cell chain and
// the pending register to the output: the token walks one slot per cycle.
// A clear command or a nonzero step gives its result on the next cycle.
// Reset empties the table at once through the fill count; there is no sweep.
// One event is in flight at a time; a result still waiting on out_ch holds
// off the input, and a finished search waits until the output is free.
// ----------------------------------------------------------------------------
module stuck_id_retry_tracker_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sirt_in_if.sink                       in_ch,
    sirt_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sirt_pkg::PADDR_W-1:0]  paddr,
    input  logic [sirt_pkg::PDATA_W-1:0]  pwdata,
    output logic [sirt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import sirt_pkg::*;

    t_cfg               cfg;
    t_tok               tok [0:TABLE_ENTRIES];

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_used;
    logic [CNT_W-1:0]   n_used;
    t_tok               r_launch;
    t_tok               n_launch;
    t_tok               r_pend;
    logic               pend_load;

    logic               r_out_valid;
    t_action            r_out_action;
    logic [INDEX_W-1:0] r_out_index;
    logic [HITS_W-1:0]  r_out_hits;
    logic [MOVES_W-1:0] r_out_moves;
    logic               r_out_move_y;

    logic               out_free;
    logic               in_take;
    logic               out_load;
    t_action            n_out_action;
    logic [INDEX_W-1:0] n_out_index;
    logic [HITS_W-1:0]  n_out_hits;
    logic [MOVES_W-1:0] n_out_moves;
    logic               n_out_move_y;

    // Configuration registers.
    sirt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Chain of table cells.
    assign tok[0] = r_launch;
    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        sirt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (cfg),
            .i_tok   (tok[k]),
            .o_tok   (tok[k+1])
        );
    end

    assign out_free       = !r_out_valid || out_ch.ready;
    assign in_ch.ready    = (r_state == ST_IDLE) && out_free;
    assign in_take        = in_ch.valid && in_ch.ready;

    assign out_ch.valid       = r_out_valid;
    assign out_ch.action      = r_out_action;
    assign out_ch.entry_index = r_out_index;
    assign out_ch.hit_count   = r_out_hits;
    assign out_ch.move_count  = r_out_moves;
    assign out_ch.move_y      = r_out_move_y;

    // Next state, token launch and result selection.
    always_comb begin
        n_state         = r_state;
        n_used          = r_used;
        n_launch        = r_launch;
        n_launch.active = 1'b0;
        pend_load       = 1'b0;
        out_load        = 1'b0;
        n_out_action    = ACT_NONE;
        n_out_index     = '0;
        n_out_hits      = '0;
        n_out_moves     = '0;
        n_out_move_y    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (in_ch.command) begin
                        n_used   = '0;
                        out_load = 1'b1;
                    end else if (!in_ch.step_is_zero) begin
                        out_load = 1'b1;
                    end else begin
                        n_launch.active = 1'b1;
                        n_launch.id     = in_ch.track_id;
                        n_launch.used   = r_used;
                        n_launch.slot   = '0;
                        n_launch.done   = 1'b0;
                        n_launch.action = ACT_FULL;
                        n_launch.res_slot = '0;
                        n_launch.hits   = '0;
                        n_launch.moves  = '0;
                        n_launch.move_y = 1'b0;
                        n_state         = ST_BUSY;
                    end
                end
            end
            ST_BUSY: begin
                if (tok[TABLE_ENTRIES].active) begin
                    pend_load = 1'b1;
                    if (tok[TABLE_ENTRIES].done &&
                        (tok[TABLE_ENTRIES].action == ACT_INSERTED)) begin
                        n_used = r_used + 1'b1;
                    end
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_pend.done) begin
                        n_out_action = r_pend.action;
                        n_out_index  = slot_to_index(r_pend.res_slot);
                        n_out_hits   = r_pend.hits;
                        n_out_moves  = r_pend.moves;
                        n_out_move_y = r_pend.move_y;
                    end else begin
                        n_out_action = ACT_FULL;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_used          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_used          <= n_used;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Token at the chain head; only its valid flag is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch.active <= 1'b0;
        end else begin
            r_launch.active <= n_launch.active;
        end
        r_launch.id       <= n_launch.id;
        r_launch.used     <= n_launch.used;
        r_launch.slot     <= n_launch.slot;
        r_launch.done     <= n_launch.done;
        r_launch.action   <= n_launch.action;
        r_launch.res_slot <= n_launch.res_slot;
        r_launch.hits     <= n_launch.hits;
        r_launch.moves    <= n_launch.moves;
        r_launch.move_y   <= n_launch.move_y;
    end

    // Finished token held until the output register is free.
    always_ff @(posedge i_clk) begin
        if (pend_load) begin
            r_pend <= tok[TABLE_ENTRIES];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_action <= n_out_action;
            r_out_index  <= n_out_index;
            r_out_hits   <= n_out_hits;
            r_out_moves  <= n_out_moves;
            r_out_move_y <= n_out_move_y;
        end
    end

endmodule

/* hdl/sirt_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_cfg: configuration registers
// APB-style register file holding the thresholds, limits and decrement.
// ----------------------------------------------------------------------------
module sirt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sirt_pkg::PADDR_W-1:0]  paddr,
    input  logic [sirt_pkg::PDATA_W-1:0]  pwdata,
    output logic [sirt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output sirt_pkg::t_cfg                o_cfg
);
    import sirt_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    t_reg_idx   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign o_cfg   = r_cfg;

    // Register writes; each register keeps the low bits of the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_threshold  <= 8'd10;
            r_cfg.abort_threshold <= 8'd50;
            r_cfg.move_limit      <= 4'd10;
            r_cfg.y_move_after    <= 4'd5;
            r_cfg.count_decrement <= 8'd2;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MOVE_THRESHOLD:  r_cfg.move_threshold  <= pwdata[HITS_W-1:0];
                REG_ABORT_THRESHOLD: r_cfg.abort_threshold <= pwdata[HITS_W-1:0];
                REG_MOVE_LIMIT:      r_cfg.move_limit      <= pwdata[MOVES_W-1:0];
                REG_Y_MOVE_AFTER:    r_cfg.y_move_after    <= pwdata[MOVES_W-1:0];
                REG_COUNT_DECREMENT: r_cfg.count_decrement <= pwdata[HITS_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data.
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_MOVE_THRESHOLD:  prdata = PDATA_W'(r_cfg.move_threshold);
            REG_ABORT_THRESHOLD: prdata = PDATA_W'(r_cfg.abort_threshold);
            REG_MOVE_LIMIT:      prdata = PDATA_W'(r_cfg.move_limit);
            REG_Y_MOVE_AFTER:    prdata = PDATA_W'(r_cfg.y_move_after);
            REG_COUNT_DECREMENT: prdata = PDATA_W'(r_cfg.count_decrement);
            default:             prdata = '0;
        endcase
    end

endmodule

/* hdl/sirt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_cell: one table slot of the tracker chain
// Holds one identifier with its hit and move counts. Each cell registers the
// search token; a matching slot applies the decision, and the first
// free slot takes the identifier when no earlier slot matched.
// ----------------------------------------------------------------------------
module sirt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sirt_pkg::t_cfg  i_cfg,
    input  sirt_pkg::t_tok  i_tok,
    output sirt_pkg::t_tok  o_tok
);
    import sirt_pkg::*;

    logic [ID_W-1:0]    r_id;
    logic [HITS_W-1:0]  r_hits;
    logic [MOVES_W-1:0] r_moves;
    t_tok               r_tok;

    logic [ID_W-1:0]    n_id;
    logic [HITS_W-1:0]  n_hits;
    logic [MOVES_W-1:0] n_moves;
    logic               wr_en;
    t_tok               n_tok;
    logic               live;
    logic [CNT_W-1:0]   slot_ext;

    assign live     = i_tok.active && !i_tok.done;
    assign slot_ext = CNT_W'(i_tok.slot);
    assign o_tok    = r_tok;

    // Match, decision and insertion for this slot.
    always_comb begin
        n_tok      = i_tok;
        n_tok.slot = i_tok.slot + 1'b1;
        n_id       = r_id;
        n_hits     = r_hits;
        n_moves    = r_moves;
        wr_en      = 1'b0;

        if (live && (slot_ext < i_tok.used) && (r_id == i_tok.id)) begin
            n_tok.done     = 1'b1;
            n_tok.res_slot = i_tok.slot;
            if ((r_hits > i_cfg.move_threshold) && (r_moves < i_cfg.move_limit)) begin
                wr_en        = 1'b1;
                n_moves      = r_moves + 1'b1;
                n_hits       = (r_hits > i_cfg.count_decrement) ?
                               (r_hits - i_cfg.count_decrement) : '0;
                n_tok.action = ACT_MOVE;
                n_tok.move_y = (r_moves > i_cfg.y_move_after);
            end else if (r_hits > i_cfg.abort_threshold) begin
                n_tok.action = ACT_ABORT;
                n_tok.move_y = 1'b0;
            end else begin
                wr_en        = 1'b1;
                n_hits       = (r_hits == HITS_MAX) ? r_hits : (r_hits + 1'b1);
                n_tok.action = ACT_COUNTED;
                n_tok.move_y = 1'b0;
            end
            n_tok.hits  = n_hits;
            n_tok.moves = n_moves;
        end else if (live && (slot_ext == i_tok.used)) begin
            // First free slot: every used slot has been checked already.
            wr_en          = 1'b1;
            n_id           = i_tok.id;
            n_hits         = HITS_W'(1);
            n_moves        = '0;
            n_tok.done     = 1'b1;
            n_tok.res_slot = i_tok.slot;
            n_tok.action   = ACT_INSERTED;
            n_tok.hits     = HITS_W'(1);
            n_tok.moves    = '0;
            n_tok.move_y   = 1'b0;
        end
    end

    // Slot contents.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_id    <= n_id;
            r_hits  <= n_hits;
            r_moves <= n_moves;
        end
    end

    // Token stage towards the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.active <= 1'b0;
        end else begin
            r_tok.active <= n_tok.active;
        end
        r_tok.id       <= n_tok.id;
        r_tok.used     <= n_tok.used;
        r_tok.slot     <= n_tok.slot;
        r_tok.done     <= n_tok.done;
        r_tok.action   <= n_tok.action;
        r_tok.res_slot <= n_tok.res_slot;
        r_tok.hits     <= n_tok.hits;
        r_tok.moves    <= n_tok.moves;
        r_tok.move_y   <= n_tok.move_y;
    end

endmodule
